FILE: rtl/ump_pkg.sv
`default_nettype none

package ump_pkg;

    // Fixed field widths of the stream items.
    localparam int BYTE_W       = 8;
    localparam int ELEM_W       = 64;
    localparam int GROUP_W      = 6;
    localparam int GROUPS       = 1 << GROUP_W;
    localparam int COUNT_W      = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int TDATA_W      = ((ELEM_W + GROUP_W + 7) / 8) * 8;

    // Pooling geometry.
    localparam int LANES        = 8;
    localparam int DATA_W       = LANES * BYTE_W;
    localparam int MAX_CHANNELS = 512;
    localparam int CH_W         = $clog2(MAX_CHANNELS) + 2;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0]  CLAMP_MIN_RST     = 8'd0;
    localparam logic [BYTE_W-1:0]  CLAMP_MAX_RST     = 8'd255;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 10'd512;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CLAMP_MIN     = 2'd0,
        REG_CLAMP_MAX     = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  clamp_min;
        logic [BYTE_W-1:0]  clamp_max;
        logic [COUNT_W-1:0] channel_count;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]  bytes;
        logic [GROUP_W-1:0] group;
        logic               first;
        logic               last;
    } item_t;

    typedef struct packed {
        logic               en;
        logic [GROUP_W-1:0] addr;
        logic [DATA_W-1:0]  data;
    } store_wr_t;

    typedef struct packed {
        logic ready;
        logic busy;
        logic advance;
        logic advance_last;
    } pool_status_t;

endpackage

`default_nettype wire

FILE: rtl/ump_store.sv
`default_nettype none

module ump_store
    import ump_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               rd_en,
    input  wire logic [GROUP_W-1:0] rd_addr,
    output logic      [DATA_W-1:0]  rd_data,
    input  wire store_wr_t          wr
);

    // One running-maximum word per channel group.
    logic [DATA_W-1:0] mem [GROUPS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read data holds until the next read, so a stalled item keeps its operand.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ump_pool_stage.sv
`default_nettype none

module ump_pool_stage
    import ump_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire item_t               in_item,
    input  wire logic [DATA_W-1:0]   rd_data,
    input  wire cfg_t                cfg,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic      [DATA_W-1:0]   out_bytes,
    output logic      [GROUP_W-1:0]  out_group,
    output store_wr_t                wr,
    output pool_status_t             status
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    item_t              s1_item_reg;

    logic               fwd_valid_reg;
    logic [GROUP_W-1:0] fwd_group_reg;
    logic [DATA_W-1:0]  fwd_data_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_bytes_reg;
    logic [GROUP_W-1:0] out_group_reg;

    logic [DATA_W-1:0]  prev;
    logic [DATA_W-1:0]  acc;
    logic [DATA_W-1:0]  res;
    logic [CH_W-1:0]    used;
    logic               out_free;
    logic               advance;

    // The item ahead wrote its entry on the same edge this item read it.
    assign prev = (fwd_valid_reg && (fwd_group_reg == s1_item_reg.group)) ?
                  fwd_data_reg : rd_data;

    assign used = (CH_W'(cfg.channel_count) > CH_W'(MAX_CHANNELS)) ?
                  CH_W'(MAX_CHANNELS) : CH_W'(cfg.channel_count);

    always_comb begin
        logic [BYTE_W-1:0] v;
        logic [BYTE_W-1:0] p;
        logic [CH_W-1:0]   ch;
        acc = '0;
        res = '0;
        for (int lane = 0; lane < LANES; lane++) begin
            v = s1_item_reg.bytes[lane*BYTE_W +: BYTE_W];
            p = prev[lane*BYTE_W +: BYTE_W];
            if (!s1_item_reg.first && (p > v)) begin
                v = p;
            end
            acc[lane*BYTE_W +: BYTE_W] = v;
            if (v < cfg.clamp_min) begin
                v = cfg.clamp_min;
            end
            if (v > cfg.clamp_max) begin
                v = cfg.clamp_max;
            end
            ch = CH_W'(s1_item_reg.group) * CH_W'(LANES) + CH_W'(lane);
            if (ch < used) begin
                res[lane*BYTE_W +: BYTE_W] = v;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && (!s1_item_reg.last || out_free);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && s1_item_reg.last) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg <= in_item;
        end
        if (advance) begin
            fwd_group_reg <= s1_item_reg.group;
            fwd_data_reg  <= acc;
        end
        if (advance && s1_item_reg.last) begin
            out_bytes_reg <= res;
            out_group_reg <= s1_item_reg.group;
        end
    end

    assign wr.en   = advance;
    assign wr.addr = s1_item_reg.group;
    assign wr.data = acc;

    assign out_valid = out_valid_reg;
    assign out_bytes = out_bytes_reg;
    assign out_group = out_group_reg;

    assign status.ready        = !s1_valid_reg || advance;
    assign status.busy         = s1_valid_reg;
    assign status.advance      = advance;
    assign status.advance_last = advance && s1_item_reg.last;

endmodule

`default_nettype wire

FILE: rtl/u8_max_pool_clamp_core.sv
// Unsigned 8-bit max pooling over groups of eight channels, with a final clamp.
// Input stream (s_*): each beat is one pooling-window element of one channel
// group. tlast marks the last element of the window and tuser the first one.
// A first element loads the group's running maximum; later ones take the
// per-lane maximum with it. A last element emits one result beat on m_*:
// the running maximum clamped to [clamp_min, clamp_max], with lanes at or
// beyond channel_count forced to zero.
// Configuration is written through cfg_* (index 0 clamp_min, 1 clamp_max,
// 2 channel_count) while the stream is idle; cfg_ready is always high.
// An accepted beat and its running-maximum memory read are registered in the
// pool stage, and its result is then registered in the output register.
// Throughput: one beat per cycle unless a result beat stalls, set by the single
// memory read-modify-write per beat; back-to-back same-group beats are forwarded.
// When the receiver stalls, the output register holds its beat and the stage
// behind it keeps taking elements until a second last element has to wait.
// Reset clears the pipeline and loads the configuration reset values; memory entries
// hold nothing defined until a first element of that group has written them.
`default_nettype none

module u8_max_pool_clamp_core
    import ump_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_W-1:0]     s_tdata,   // element_bytes, channel_group
    input  wire logic                   s_tuser,   // first_element
    input  wire logic                   s_tlast,   // last_element
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [TDATA_W-1:0]     m_tdata,   // result_bytes, result_group
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t              cfg_reg;
    logic              in_accept;
    item_t             in_item;
    logic [DATA_W-1:0] rd_data;
    store_wr_t         wr;
    pool_status_t      status;
    logic [DATA_W-1:0] out_bytes;
    logic [GROUP_W-1:0] out_group;

    // Configuration registers. Writes to an unused index are taken and dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clamp_min     <= CLAMP_MIN_RST;
            cfg_reg.clamp_max     <= CLAMP_MAX_RST;
            cfg_reg.channel_count <= CHANNEL_COUNT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CLAMP_MIN:     cfg_reg.clamp_min     <= cfg_data[BYTE_W-1:0];
                REG_CLAMP_MAX:     cfg_reg.clamp_max     <= cfg_data[BYTE_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the input beat. Lanes past LANES are not pooled.
    assign in_item.bytes = s_tdata[DATA_W-1:0];
    assign in_item.group = s_tdata[ELEM_W +: GROUP_W];
    assign in_item.first = s_tuser;
    assign in_item.last  = s_tlast;

    assign s_tready  = status.ready;
    assign in_accept = s_tvalid && s_tready;

    // The memory is read on the accepting edge; the pool stage sees the registered
    // word and writes the updated maximum back when it advances.
    ump_store u_store (
        .aclk    (aclk),
        .rd_en   (in_accept),
        .rd_addr (in_item.group),
        .rd_data (rd_data),
        .wr      (wr)
    );

    ump_pool_stage u_pool (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_item   (in_item),
        .rd_data   (rd_data),
        .cfg       (cfg_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_bytes (out_bytes),
        .out_group (out_group),
        .wr        (wr),
        .status    (status)
    );

    assign m_tdata = {(TDATA_W - ELEM_W - GROUP_W)'(0), out_group,
                      ELEM_W'(out_bytes)};

    // Input back-pressure only ever comes from a stalled result beat.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

    // A last element leaving the pool stage always lands in the output register.
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        status.advance_last |=> m_tvalid)
        else $error("last element produced no result beat");

    // An accepted beat is held in the pool stage on the next cycle.
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> status.busy)
        else $error("accepted beat lost before the pool stage");

endmodule

`default_nettype wire

FILE: bench/u8_max_pool_clamp_core_tb.sv
`default_nettype none

// Self-checking bench for the unsigned 8-bit max pooling core.
// Window elements are streamed into s_* and pooled results are collected from m_*.
// A local model tracks the running maximum of every channel group and the three
// configuration registers. Each accepted element is folded into that model, and
// every last element queues the clamped result that the core must return.
module u8_max_pool_clamp_core_tb;
    import ump_pkg::*;

    localparam int SEND_GAP_MAX = 11;
    localparam int RECV_GAP_MAX = 11;
    // Covers elements that are still in flight without producing a result.
    localparam int SETTLE_CYCLES = 8;

    // One pooled result as it should appear on m_tdata.
    typedef struct {
        logic [DATA_W-1:0]  bytes;
        logic [GROUP_W-1:0] grp;
    } pooled_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Model state: one running maximum per channel group, plus the registers.
    logic [DATA_W-1:0]  pool_max [GROUPS];
    bit                 group_loaded [GROUPS];
    logic [BYTE_W-1:0]  lo_bound;
    logic [BYTE_W-1:0]  hi_bound;
    logic [COUNT_W-1:0] used_channels;

    // Results that the core still owes, oldest first.
    pooled_t pooled_q[$];
    int      errors;

    // Traffic shaping. The quiet flags turn off random idling on one side, and
    // recv_hold asks the receiver for one long stall before its next beat.
    bit quiet_send;
    bit quiet_recv;
    int recv_hold;

    u8_max_pool_clamp_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // element_bytes, channel_group
        .s_tuser   (s_tuser),   // first_element
        .s_tlast   (s_tlast),   // last_element
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // result_bytes, result_group
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Folds one accepted element into the model. A last element queues the
    // clamped result, with lanes past the channel count forced to zero.
    function automatic void pool_element(input logic [DATA_W-1:0] bytes,
                                         input logic [GROUP_W-1:0] grp,
                                         input bit is_first, input bit is_last);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] clamped;
        logic [BYTE_W-1:0] v;
        int unsigned       in_use;
        int unsigned       ch;
        pooled_t           res;
        acc = '0;
        clamped = '0;
        for (int lane = 0; lane < LANES; lane++) begin
            v = bytes[lane*BYTE_W +: BYTE_W];
            if (!is_first && pool_max[grp][lane*BYTE_W +: BYTE_W] > v)
                v = pool_max[grp][lane*BYTE_W +: BYTE_W];
            acc[lane*BYTE_W +: BYTE_W] = v;
        end
        pool_max[grp] = acc;
        if (is_first)
            group_loaded[grp] = 1'b1;
        if (!is_last)
            return;
        // Counts beyond the channel limit saturate to it.
        in_use = (used_channels > MAX_CHANNELS) ? MAX_CHANNELS : used_channels;
        for (int lane = 0; lane < LANES; lane++) begin
            ch = grp * LANES + lane;
            v = acc[lane*BYTE_W +: BYTE_W];
            // The upper bound is applied last, so crossed bounds give clamp_max.
            if (v < lo_bound)
                v = lo_bound;
            if (v > hi_bound)
                v = hi_bound;
            if (ch < in_use)
                clamped[lane*BYTE_W +: BYTE_W] = v;
        end
        res.bytes = clamped;
        res.grp = grp;
        pooled_q.push_back(res);
    endfunction

    // Random channel bytes, with whole lanes often pinned to 0x00 or 0xFF so
    // that both clamp bounds are hit regularly.
    function automatic logic [DATA_W-1:0] random_bytes();
        logic [DATA_W-1:0] b;
        b = {$urandom, $urandom};
        for (int lane = 0; lane < LANES; lane++) begin
            case ($urandom_range(0, 7))
                0: b[lane*BYTE_W +: BYTE_W] = '0;
                1: b[lane*BYTE_W +: BYTE_W] = '1;
                default: ;
            endcase
        end
        return b;
    endfunction

    // Half of the groups are drawn near the group that the channel count cuts.
    function automatic logic [GROUP_W-1:0] pick_group();
        int border;
        logic [GROUP_W-1:0] grp;
        if ($urandom_range(0, 1)) begin
            grp = GROUP_W'($urandom_range(0, GROUPS - 1));
        end else begin
            border = (used_channels > MAX_CHANNELS) ? MAX_CHANNELS : used_channels;
            border = border / LANES + int'($urandom_range(0, 2)) - 1;
            if (border < 0)
                border = 0;
            if (border > GROUPS - 1)
                border = GROUPS - 1;
            grp = GROUP_W'(border);
        end
        return grp;
    endfunction

    // Sends one element: an optional idle gap, then tvalid held until the beat
    // is taken. tvalid is left high so back-to-back beats need no second write
    // of it in the same time step.
    task automatic send_element(input logic [DATA_W-1:0] bytes,
                                input logic [GROUP_W-1:0] grp,
                                input bit is_first, input bit is_last);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, SEND_GAP_MAX);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - ELEM_W - GROUP_W){1'b0}}, grp, ELEM_W'(bytes)};
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        pool_element(bytes, grp, is_first, is_last);
    endtask

    // Stops offering beats and waits until the core has returned every result,
    // then lets the pipeline settle so no element without a result is in flight.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pooled_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CLAMP_MIN:     lo_bound = value[BYTE_W-1:0];
            REG_CLAMP_MAX:     hi_bound = value[BYTE_W-1:0];
            REG_CHANNEL_COUNT: used_channels = value[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Registers are only rewritten once the stream is idle. The unused upper
    // bits of the clamp writes carry junk, which the core must ignore.
    task automatic apply_settings(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
                                  input logic [COUNT_W-1:0] cnt);
        logic [CFG_DATA_W-BYTE_W-1:0] junk;
        drain_results();
        junk = (CFG_DATA_W - BYTE_W)'($urandom_range(0, 3));
        write_reg(REG_CLAMP_MIN, {junk, lo});
        junk = (CFG_DATA_W - BYTE_W)'($urandom_range(0, 3));
        write_reg(REG_CLAMP_MAX, {junk, hi});
        write_reg(REG_CHANNEL_COUNT, cnt);
    endtask

    // A well-formed window: first mark on the opening element, last on the closing one.
    task automatic run_window(input logic [GROUP_W-1:0] grp, input int len);
        for (int i = 0; i < len; i++)
            send_element(random_bytes(), grp, i == 0, i == len - 1);
    endtask

    // Two windows of neighboring groups interleaved element by element.
    task automatic run_pair(input logic [GROUP_W-1:0] grp, input int len);
        logic [GROUP_W-1:0] other;
        other = grp ^ 6'd1;
        for (int i = 0; i < len; i++) begin
            send_element(random_bytes(), grp, i == 0, i == len - 1);
            send_element(random_bytes(), other, i == 0, i == len - 1);
        end
    endtask

    // Hand-picked windows at the reset settings: byte extremes, both end groups,
    // one-element windows, a window continued after its result, interleaved
    // windows, back-to-back beats of one group, and a window restarted early.
    task automatic test_directed_cases();
        send_element('0, 6'd0, 1'b1, 1'b1);
        send_element('1, 6'd63, 1'b1, 1'b1);
        send_element(64'h0102_0304_0506_0708, 6'd5, 1'b1, 1'b0);
        send_element(64'h0801_0703_0605_0507, 6'd5, 1'b0, 1'b0);
        send_element(64'h0000_FF00_0000_0080, 6'd5, 1'b0, 1'b1);
        // No first mark: the maximum left by the earlier window carries on.
        send_element('0, 6'd63, 1'b0, 1'b1);
        send_element(64'h5555_5555_5555_5555, 6'd0, 1'b1, 1'b1);
        send_element(64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 1'b1, 1'b1);
        send_element(64'h1000_2000_3000_4000, 6'd1, 1'b1, 1'b0);
        send_element(64'h0040_0030_0020_0010, 6'd2, 1'b1, 1'b0);
        send_element(64'h0011_0022_0033_0044, 6'd1, 1'b0, 1'b1);
        send_element(64'h4400_3300_2200_1100, 6'd2, 1'b0, 1'b1);
        // Back-to-back beats of one group exercise the read-after-write path.
        quiet_send = 1'b1;
        send_element(64'h0101_0101_0101_0101, 6'd7, 1'b1, 1'b0);
        send_element(64'h0202_0202_0202_0202, 6'd7, 1'b0, 1'b0);
        send_element(64'h0103_0103_0103_0103, 6'd7, 1'b0, 1'b0);
        send_element(64'h0400_0400_0400_0400, 6'd7, 1'b0, 1'b1);
        // A second first mark discards the maximum gathered so far.
        send_element(64'hF0F0_F0F0_F0F0_F0F0, 6'd9, 1'b1, 1'b0);
        send_element(64'h0F0F_0F0F_0F0F_0F0F, 6'd9, 1'b1, 1'b1);
        quiet_send = 1'b0;
        drain_results();
    endtask

    task automatic sweep_one(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
                             input logic [COUNT_W-1:0] cnt, input int items);
        int sent;
        int len;
        apply_settings(lo, hi, cnt);
        quiet_send = ($urandom_range(0, 3) == 0);
        quiet_recv = ($urandom_range(0, 3) == 0);
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            run_window(pick_group(), len);
            sent += len;
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    // Walks the registers through their extremes and the special settings:
    // crossed bounds, a zero count, a count above the channel limit and
    // counts that cut a group in the middle.
    task automatic test_clamp_settings();
        sweep_one(8'd0, 8'd255, 10'd512, 100);
        sweep_one(8'd0, 8'd0, 10'd1, 100);
        sweep_one(8'd255, 8'd255, 10'd511, 100);
        sweep_one(8'd40, 8'd200, 10'd300, 100);
        sweep_one(8'd200, 8'd40, 10'd512, 100);
        sweep_one(8'd0, 8'd255, 10'd0, 100);
        sweep_one(8'd10, 8'd250, 10'd1023, 100);
        sweep_one(8'd0, 8'd255, 10'd13, 100);
        sweep_one(8'd128, 8'd128, 10'd8, 100);
        sweep_one(8'd1, 8'd254, 10'd520, 100);
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering
    // beats without gaps, so the core fills up and has to drop s_tready.
    task automatic test_backpressure();
        apply_settings(8'd20, 8'd230, 10'd512);
        quiet_send = 1'b1;
        recv_hold = 200;
        for (int w = 0; w < 25; w++)
            run_window(pick_group(), $urandom_range(1, 3));
        quiet_send = 1'b0;
        drain_results();
    endtask

    // The sender goes silent until every owed result has come back, then resumes.
    task automatic test_sender_pause();
        for (int r = 0; r < 3; r++) begin
            for (int w = 0; w < 8; w++)
                run_window(pick_group(), $urandom_range(1, 4));
            drain_results();
        end
    endtask

    // Mostly well-formed windows with random content, mixed with stray
    // elements whose marks are random: windows left open, restarted or
    // closed twice. Stray elements only skip the first mark on loaded groups.
    task automatic test_random_mix();
        int sent;
        int len;
        logic [GROUP_W-1:0] grp;
        logic [COUNT_W-1:0] cnt;
        bit is_first;
        bit is_last;
        for (int phase = 0; phase < 4; phase++) begin
            cnt = $urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 1023))
                                       : COUNT_W'($urandom_range(0, 63) * LANES
                                                  + $urandom_range(0, 7));
            apply_settings(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                           cnt);
            sent = 0;
            while (sent < 150) begin
                if ($urandom_range(0, 9) == 0) begin
                    quiet_send = ($urandom_range(0, 3) == 0);
                    quiet_recv = ($urandom_range(0, 3) == 0);
                end
                grp = pick_group();
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                case ($urandom_range(0, 7))
                    0, 1: begin
                        is_first = !group_loaded[grp] || ($urandom_range(0, 2) == 0);
                        is_last = ($urandom_range(0, 1) == 1);
                        send_element(random_bytes(), grp, is_first, is_last);
                        sent += 1;
                    end
                    2: begin
                        run_pair(grp, len);
                        sent += 2 * len;
                    end
                    default: begin
                        run_window(grp, len);
                        sent += len;
                    end
                endcase
            end
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    // Result receiver. Before each beat it draws a stall, or takes the long
    // hold-off if one was requested, then keeps m_tready high until a beat moves.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = quiet_recv ? 0 : $urandom_range(0, RECV_GAP_MAX);
            if (recv_hold > 0) begin
                stall = recv_hold;
                recv_hold = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Every result beat is matched against the oldest owed result, field by field.
    // The padding bits above the group field must stay zero.
    always @(posedge aclk) begin : result_check
        pooled_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pooled_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with none owed, expected nothing, actual %h",
                         $time, m_tdata);
            end else begin
                want = pooled_q.pop_front();
                if (m_tdata[ELEM_W-1:0] !== ELEM_W'(want.bytes)) begin
                    errors++;
                    $display("%0t: result_bytes mismatch, expected %h, actual %h",
                             $time, ELEM_W'(want.bytes), m_tdata[ELEM_W-1:0]);
                end
                if (m_tdata[ELEM_W +: GROUP_W] !== want.grp) begin
                    errors++;
                    $display("%0t: result_group mismatch, expected %0d, actual %0d",
                             $time, want.grp, m_tdata[ELEM_W +: GROUP_W]);
                end
                if (m_tdata[TDATA_W-1:ELEM_W+GROUP_W] !== '0) begin
                    errors++;
                    $display("%0t: tdata padding mismatch, expected 0, actual %h",
                             $time, m_tdata[TDATA_W-1:ELEM_W+GROUP_W]);
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run of the whole regression.
    initial begin : watchdog
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : regression
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_CLAMP_MIN;
        cfg_data      = '0;
        errors        = 0;
        quiet_send    = 1'b0;
        quiet_recv    = 1'b0;
        recv_hold     = 0;
        lo_bound      = CLAMP_MIN_RST;
        hi_bound      = CLAMP_MAX_RST;
        used_channels = CHANNEL_COUNT_RST;
        for (int g = 0; g < GROUPS; g++)
            group_loaded[g] = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_clamp_settings();
        test_backpressure();
        test_sender_pause();
        test_random_mix();
        drain_results();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/ump_pkg.sv
rtl/ump_store.sv
rtl/ump_pool_stage.sv
rtl/u8_max_pool_clamp_core.sv
bench/u8_max_pool_clamp_core_tb.sv
